// File: rtl/bmm_pkg.sv
// Package for the bipartite matching block: sizes, constants, controller states.
// Used by every module of the block; depends on nothing.
package bmm_pkg;

    localparam int MaxLeft  = 64;
    localparam int MaxRight = 64;
    localparam int LW = $clog2(MaxLeft);
    localparam int RW = $clog2(MaxRight);
    localparam int CntW = 7;
    localparam int RowW = 64;

    localparam logic CFG_LEFT_COUNT  = 1'b0;
    localparam logic CFG_RIGHT_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_ROOT,
        ST_FETCH,
        ST_SCAN,
        ST_PUSH,
        ST_AUG,
        ST_OUT_RD,
        ST_OUT
    } bmm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic store_row;
        logic clear_step;
        logic start_root;
        logic fetch;
        logic scan;
        logic push;
        logic pop;
        logic next_root;
        logic aug_step;
        logic out_read;
        logic out_next;
        logic run_reset;
    } bmm_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic clear_done;
        logic found;
        logic free_right;
        logic stack_empty;
        logic stack_full;
        logic aug_last;
        logic root_last;
        logic out_last;
    } bmm_status_t;

endpackage

// File: rtl/bmm_if.sv
// Valid/ready channel interfaces for row requests and result requests.
// Depends on bmm_pkg.
interface bmm_in_if import bmm_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [RowW-1:0] row_bits;
    logic            last_row;
    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink (input valid, input row_bits, input last_row, output ready);
endinterface

interface bmm_out_if import bmm_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [LW-1:0] left_index;
    logic          is_matched;
    logic [RW-1:0] right_index;
    logic          last_result;
    modport source (output valid, output left_index, output is_matched,
                    output right_index, output last_result, input ready);
    modport sink (input valid, input left_index, input is_matched,
                  input right_index, input last_result, output ready);
endinterface

// File: rtl/bipartite_max_matching.sv
// Top level of the bipartite maximum matching block.
// Depends on bmm_pkg, bmm_if, bmm_controller and bmm_datapath.
//
// Use: rows of the adjacency matrix arrive on in_ch, left vertex 0 first, one
// request per cycle while loading. The request with last_row set starts the
// match, which uses left_count and right_count as written on the config port
// (clamped to 1..64). Each run first clears the partner tables. Each left
// vertex then starts an augmenting-path search with an explicit stack; every
// scanned stack frame passes the fetch row, priority scan and decide states,
// and an augment writes back one frame a cycle. Results leave on out_ch, one
// per left vertex in ascending order, each read from the partner table before
// it is offered; last_result marks the final one. A stalled receiver holds
// the current result. No row is taken while a run or its results are pending.
// Reset returns the block to loading with both counts at 64.
module bipartite_max_matching
    import bmm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bmm_in_if.sink       in_ch,
    bmm_out_if.source    out_ch,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [CntW-1:0] cfg_data
);

    logic [CntW-1:0] left_count_reg, right_count_reg;
    bmm_cmd_t    cmd;
    bmm_status_t status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= CntW'(64);
            right_count_reg <= CntW'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_COUNT:  left_count_reg  <= cfg_data;
                CFG_RIGHT_COUNT: right_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    bmm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_row),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmm_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_row      (in_ch.row_bits),
        .left_count  (left_count_reg),
        .right_count (right_count_reg),
        .res_left    (out_ch.left_index),
        .res_matched (out_ch.is_matched),
        .res_right   (out_ch.right_index),
        .res_last    (out_ch.last_result)
    );

endmodule

// File: rtl/bmm_datapath.sv
// Datapath of the matching block: row memory, partner tables, stack, scan logic.
// Depends on bmm_pkg; driven by bmm_controller.
module bmm_datapath
    import bmm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  bmm_cmd_t        cmd,
    output bmm_status_t     status,
    input  logic [RowW-1:0] in_row,
    input  logic [CntW-1:0] left_count,
    input  logic [CntW-1:0] right_count,
    output logic [LW-1:0]   res_left,
    output logic            res_matched,
    output logic [RW-1:0]   res_right,
    output logic            res_last
);

    logic [RowW-1:0] adj_mem [MaxLeft];
    logic [LW:0]     lp_mem  [MaxLeft];
    logic [LW:0]     ro_mem  [MaxRight];
    logic [LW+RW:0]  stk_mem [MaxLeft];

    logic [CntW-1:0] rows_reg, rows_next;
    logic [LW:0]     depth_reg;
    logic [LW-1:0]   root_reg;
    logic [RW-1:0]   clr_reg;
    logic [LW-1:0]   out_reg;
    logic [RowW-1:0] row_reg;
    logic [MaxRight-1:0] vis_reg;
    logic            found_reg;
    logic [LW:0]     owner_reg;
    logic [LW:0]     lp_rd_reg;
    logic [LW-1:0]   top_left_reg;
    logic [RW:0]     top_next_reg;
    logic [LW+RW:0]  stk_rd_reg;
    logic [LW-1:0]   stk_rd_addr;
    logic [LW-1:0]   nl_m1;
    logic [RW:0]     nr;
    logic [RowW-1:0] rmask, cand;
    logic [RW:0]     start_j;
    logic [RW-1:0]   first_j;
    logic            any;
    logic [LW-1:0]   aug_l;
    logic [RW-1:0]   aug_r;

    // Clamped counts.
    always_comb
    begin
        if (left_count == '0)
            nl_m1 = '0;
        else if (left_count > CntW'(MaxLeft))
            nl_m1 = LW'(MaxLeft - 1);
        else
            nl_m1 = LW'(left_count - 1'b1);
        if (right_count == '0)
            nr = (RW+1)'(1);
        else if (right_count > CntW'(MaxRight))
            nr = (RW+1)'(MaxRight);
        else
            nr = (RW+1)'(right_count);
    end

    always_comb
    begin
        for (int b = 0; b < RowW; b++)
            rmask[b] = (b < MaxRight) && ((RW+1)'(b) < nr);
    end

    // The top frame lives in registers; the frames below it sit in the stack memory.
    assign start_j = top_next_reg;

    // Candidate right vertices: edge present, in range, unvisited, at or after the cursor.
    always_comb
    begin
        for (int b = 0; b < RowW; b++)
            cand[b] = row_reg[b] & rmask[b] & ((b >= MaxRight) ? 1'b0 : ~vis_reg[b])
                      & ((RW+1)'(b) >= start_j);
    end

    // Lowest set bit of the candidate word.
    always_comb
    begin
        any = 1'b0;
        first_j = '0;
        for (int b = RowW - 1; b >= 0; b--)
        begin
            if (cand[b])
            begin
                any = 1'b1;
                first_j = RW'(b);
            end
        end
    end

    assign aug_l = top_left_reg;
    assign aug_r = RW'(top_next_reg - 1'b1);

    // The stack is read one frame below the top, or two below while augmenting,
    // so that the frame that becomes the new top is already in the registered read when it is needed.
    assign stk_rd_addr = cmd.aug_step ? LW'(depth_reg - (LW+1)'(3))
                                      : LW'(depth_reg - (LW+1)'(2));

    assign rows_next = (rows_reg < CntW'(MaxLeft)) ? rows_reg + 1'b1 : rows_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= '0;
            depth_reg <= '0;
            root_reg  <= '0;
            clr_reg   <= '0;
            out_reg   <= '0;
            vis_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.store_row)
                rows_reg <= rows_next;
            if (cmd.run_reset)
            begin
                rows_reg <= '0;
                clr_reg  <= '0;
                root_reg <= '0;
                out_reg  <= '0;
            end
            if (cmd.clear_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.start_root)
            begin
                depth_reg <= (LW+1)'(1);
                vis_reg   <= '0;
            end
            if (cmd.scan)
            begin
                found_reg <= any;
                if (any)
                    vis_reg[first_j] <= 1'b1;
                else
                    depth_reg <= depth_reg - 1'b1;
            end
            if (cmd.next_root)
                root_reg <= root_reg + 1'b1;
            if (cmd.push)
                depth_reg <= depth_reg + 1'b1;
            if (cmd.aug_step)
            begin
                depth_reg <= depth_reg - 1'b1;
                if (depth_reg == (LW+1)'(1))
                    root_reg <= root_reg + 1'b1;
            end
            if (cmd.out_next)
                out_reg <= out_reg + 1'b1;
        end
    end

    // Row memory and fetch of the top-of-stack row.
    always_ff @(posedge clk)
    begin
        if (cmd.store_row && rows_reg < CntW'(MaxLeft))
            adj_mem[rows_reg[LW-1:0]] <= in_row;
        if (cmd.fetch)
            row_reg <= adj_mem[top_left_reg];
    end

    // Partner tables, owner lookup and stack.
    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stk_mem[stk_rd_addr];
        if (cmd.clear_step)
        begin
            lp_mem[LW'(clr_reg)] <= '1;
            ro_mem[clr_reg]      <= '1;
        end
        if (cmd.scan && any)
        begin
            owner_reg    <= ro_mem[first_j];
            top_next_reg <= (RW+1)'(first_j) + 1'b1;
        end
        if (cmd.start_root)
        begin
            top_left_reg <= root_reg;
            top_next_reg <= '0;
        end
        if (cmd.push)
        begin
            stk_mem[LW'(depth_reg - 1'b1)] <= {top_left_reg, top_next_reg};
            top_left_reg <= owner_reg[LW-1:0];
            top_next_reg <= '0;
        end
        if (cmd.pop || cmd.aug_step)
            {top_left_reg, top_next_reg} <= stk_rd_reg;
        if (cmd.aug_step)
        begin
            lp_mem[aug_l] <= {1'b0, aug_r};
            ro_mem[aug_r] <= {1'b0, aug_l};
        end
        if (cmd.out_read)
            lp_rd_reg <= lp_mem[out_reg];
    end

    assign status.clear_done  = (clr_reg == RW'(MaxRight - 1));
    assign status.found       = found_reg;
    assign status.free_right  = owner_reg[LW];
    assign status.stack_empty = (depth_reg == '0);
    assign status.stack_full  = (depth_reg == (LW+1)'(MaxLeft));
    assign status.aug_last    = (depth_reg == (LW+1)'(1));
    assign status.root_last   = (root_reg == nl_m1);
    assign status.out_last    = (out_reg == nl_m1);

    assign res_left    = out_reg;
    assign res_matched = ~lp_rd_reg[LW];
    assign res_right   = lp_rd_reg[LW] ? '0 : RW'(lp_rd_reg[RW-1:0]);
    assign res_last    = (out_reg == nl_m1);

endmodule

// File: rtl/bmm_controller.sv
// Controller state machine of the matching block.
// Depends on bmm_pkg; commands bmm_datapath.
module bmm_controller
    import bmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_last,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  bmm_status_t status,
    output bmm_cmd_t    cmd
);

    bmm_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
                if (in_valid && in_last)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                if (status.clear_done)
                    state_next = ST_ROOT;
            ST_ROOT:
                state_next = ST_FETCH;
            ST_FETCH:
                state_next = ST_SCAN;
            ST_SCAN:
                state_next = ST_PUSH;
            ST_PUSH:
            begin
                // Pending scan result decides the move.
                if (!status.found)
                    state_next = status.stack_empty
                                 ? (status.root_last ? ST_OUT_RD : ST_ROOT) : ST_FETCH;
                else if (status.free_right)
                    state_next = ST_AUG;
                else
                    state_next = ST_FETCH;
            end
            ST_AUG:
                if (status.aug_last)
                    state_next = status.root_last ? ST_OUT_RD : ST_ROOT;
            ST_OUT_RD:
                state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = status.out_last ? ST_LOAD : ST_OUT_RD;
            default:
                state_next = ST_LOAD;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.store_row = in_valid;
                cmd.run_reset = in_valid && in_last;
            end
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_ROOT:   cmd.start_root = 1'b1;
            ST_FETCH:  cmd.fetch = 1'b1;
            ST_SCAN:   cmd.scan = 1'b1;
            ST_PUSH:
            begin
                cmd.push      = status.found && !status.free_right && !status.stack_full;
                cmd.pop       = !status.found && !status.stack_empty;
                cmd.next_root = !status.found && status.stack_empty;
            end
            ST_AUG:    cmd.aug_step = 1'b1;
            ST_OUT_RD: cmd.out_read = 1'b1;
            ST_OUT:
            begin
                out_valid = 1'b1;
                cmd.out_next = out_ready;
            end
            default: ;
        endcase
    end

endmodule
